// File: hw/rtl/chjac_pkg.sv
// Shared constants and types for the character 5-gram Jaccard block.
`default_nettype none
package chjac_pkg;

  localparam int unsigned TEXT_MAX = 1024;
  localparam int unsigned ADDR_W   = $clog2(TEXT_MAX);
  localparam int unsigned CNT_W    = ADDR_W + 1;
  localparam int unsigned GRAM_N   = 5;
  localparam int unsigned GRAM_W   = 8 * GRAM_N;
  localparam int unsigned HIST_W   = GRAM_W - 8;
  localparam int unsigned QUEUE_D  = 4;
  localparam int unsigned QPTR_W   = $clog2(QUEUE_D);

  localparam int unsigned SHARED_W = 10;
  localparam int unsigned ALL_W    = 11;
  localparam logic [7:0]  SPACE_CH = 8'h20;

  localparam logic CFG_NUM = 1'b0;
  localparam logic CFG_DEN = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_GRAM,
    OP_DONE
  } op_kind_e;

  typedef struct packed {
    op_kind_e            kind;
    logic                to_b;
    logic                ovf;
    logic [GRAM_W-1:0]   gram;
  } op_t;

endpackage
`default_nettype wire

// File: hw/rtl/chjac_if.sv
// Valid/ready channel interfaces for text bytes and similarity results.
`default_nettype none
interface chjac_in_if;
  logic       valid;
  logic       ready;
  logic       which_text;
  logic [7:0] char_byte;
  logic       last_of_text;
  modport source (output valid, which_text, char_byte, last_of_text, input ready);
  modport sink (input valid, which_text, char_byte, last_of_text, output ready);
endinterface

interface chjac_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  shared_grams;
  logic [10:0] all_grams;
  logic        is_similar;
  logic        truncated;
  modport source (output valid, shared_grams, all_grams, is_similar, truncated,
                  input ready);
  modport sink (input valid, shared_grams, all_grams, is_similar, truncated,
                output ready);
endinterface
`default_nettype wire

// File: hw/rtl/char_5gram_jaccard_similarity_core.sv
// Top level of the character 5-gram Jaccard similarity block.
// Bytes of text A, then text B, enter one per word. The front end registers a
// byte, then in turn issues a clear when the byte opens a new pair after text
// A has closed, handles each normalized byte it yields, and closes the text
// when the byte ends one; it takes no new byte meanwhile. Each new 5-gram is
// checked against its text's store by a linear scan through a registered-read
// RAM, one entry per cycle. A gram that is new to B is then checked against
// store A. A four-entry queue lets the front end keep taking bytes while the
// scan runs. The result word appears the cycle after the end of B leaves the
// queue and is held until it is taken.
`default_nettype none
module char_5gram_jaccard_similarity_core
  import chjac_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  chjac_in_if.sink        text_i,
  chjac_out_if.source     result_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);
  logic [7:0] num_q, den_q;
  logic       push, full, pop, empty;
  op_t        push_op, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= 8'd2;
      den_q <= 8'd5;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NUM) num_q <= cfg_data_i;
      if (cfg_idx_i == CFG_DEN) den_q <= cfg_data_i;
    end
  end

  chjac_front u_front (
    .clk_i, .rst_ni, .text_i, .push_o(push), .op_o(push_op), .full_i(full)
  );

  chjac_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_op_i(push_op), .full_o(full),
    .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  chjac_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop),
    .num_i(num_q), .den_i(den_q), .result_o
  );
endmodule
`default_nettype wire

// File: hw/rtl/chjac_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module chjac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/chjac_fifo.sv
// Short queue of operations between the front end and the set engine.
`default_nettype none
module chjac_fifo
  import chjac_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  push_op_i,
  output      logic full_o,
  input  wire logic pop_i,
  output      logic empty_o,
  output      op_t  head_o
);
  op_t               slot_q [QUEUE_D];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_D));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/chjac_front.sv
// Front end: byte normalization, text tracking and 5-gram assembly.
`default_nettype none
module chjac_front
  import chjac_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  chjac_in_if.sink   text_i,
  output      logic  push_o,
  output      op_t   op_o,
  input  wire logic  full_i
);
  logic              busy_q, busy_d;
  logic              tob_q, tob_d;
  logic [7:0]        ch_q, ch_d;
  logic              clr_q, clr_d, sp_q, sp_d, chp_q, chp_d, endp_q, endp_d;
  logic [HIST_W-1:0] recent_q, recent_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic              spend_q, spend_d, ovf_q, ovf_d, aclosed_q, aclosed_d;

  logic [7:0]        c, x;
  logic              kept, upper;
  logic [GRAM_W-1:0] g;

  assign text_i.ready = !busy_q;

  always_comb begin
    busy_d = busy_q; tob_d = tob_q; ch_d = ch_q;
    clr_d = clr_q; sp_d = sp_q; chp_d = chp_q; endp_d = endp_q;
    recent_d = recent_q; len_d = len_q; spend_d = spend_q;
    ovf_d = ovf_q; aclosed_d = aclosed_q;
    push_o = 1'b0;
    op_o = '{kind: OP_GRAM, to_b: tob_q, ovf: ovf_q, gram: '0};
    c = text_i.char_byte;
    upper = (c >= 8'h41) && (c <= 8'h5a);
    kept = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h30) && (c <= 8'h39)) ||
           c[7] || upper;
    x = sp_q ? SPACE_CH : ch_q;
    g = {x, recent_q};

    if (!busy_q) begin
      if (text_i.valid) begin
        tob_d = text_i.which_text;
        ch_d = upper ? (c + 8'd32) : c;
        clr_d = 1'b0;
        if (!text_i.which_text && aclosed_q) begin
          recent_d = '0; len_d = '0; spend_d = 1'b0;
          ovf_d = 1'b0; aclosed_d = 1'b0; clr_d = 1'b1;
        end else if (text_i.which_text && !aclosed_q) begin
          recent_d = '0; len_d = '0; spend_d = 1'b0; aclosed_d = 1'b1;
        end
        sp_d = 1'b0;
        chp_d = 1'b0;
        if (kept) begin
          sp_d = spend_d;
          spend_d = 1'b0;
          chp_d = 1'b1;
        end else if (c == SPACE_CH) begin
          spend_d = 1'b1;
        end
        endp_d = text_i.last_of_text;
      end
    end else if (clr_q) begin
      if (!full_i) begin
        push_o = 1'b1;
        op_o.kind = OP_CLEAR;
        clr_d = 1'b0;
      end
    end else if (sp_q || chp_q) begin
      if (!full_i) begin
        if (len_q >= CNT_W'(TEXT_MAX)) begin
          ovf_d = 1'b1;
        end else begin
          len_d = len_q + 1'b1;
          recent_d = g[GRAM_W-1:8];
          if (len_q >= CNT_W'(GRAM_N - 1)) begin
            push_o = 1'b1;
            op_o.gram = g;
          end
        end
        if (sp_q) sp_d = 1'b0;
        else chp_d = 1'b0;
      end
    end else if (endp_q) begin
      if (!tob_q) begin
        recent_d = '0; len_d = '0; spend_d = 1'b0; aclosed_d = 1'b1;
        endp_d = 1'b0;
      end else if (!full_i) begin
        push_o = 1'b1;
        op_o.kind = OP_DONE;
        recent_d = '0; len_d = '0; spend_d = 1'b0;
        ovf_d = 1'b0; aclosed_d = 1'b0;
        endp_d = 1'b0;
      end
    end
    busy_d = clr_d | sp_d | chp_d | endp_d;
  end

  always_ff @(posedge clk_i) begin
    tob_q <= tob_d;
    ch_q  <= ch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; clr_q <= 1'b0; sp_q <= 1'b0; chp_q <= 1'b0; endp_q <= 1'b0;
      recent_q <= '0; len_q <= '0; spend_q <= 1'b0; ovf_q <= 1'b0; aclosed_q <= 1'b0;
    end else begin
      busy_q <= busy_d; clr_q <= clr_d; sp_q <= sp_d; chp_q <= chp_d; endp_q <= endp_d;
      recent_q <= recent_d; len_q <= len_d; spend_q <= spend_d;
      ovf_q <= ovf_d; aclosed_q <= aclosed_d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/chjac_back.sv
// Set engine: gram stores, membership scans, counts and result register.
`default_nettype none
module chjac_back
  import chjac_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  wire op_t        head_i,
  output      logic       pop_o,
  input  wire logic [7:0] num_i,
  input  wire logic [7:0] den_i,
  chjac_out_if.source     result_o
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_XCHK = 2'd2;

  logic [1:0]        st_q, st_d;
  logic [CNT_W-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d, com_q, com_d;
  logic [CNT_W-1:0]  idx_q, idx_d, n_sel;
  logic              cmpv_q, cmpv_d, tob_q, tob_d;
  logic [GRAM_W-1:0] g_q, g_d;
  logic              rv_q, rv_d;
  logic [9:0]        rsh_q, rsh_d;
  logic [10:0]       rall_q, rall_d;
  logic              rsim_q, rsim_d, rtr_q, rtr_d;

  logic              rd_b, issue, hit;
  logic              we_a, we_b;
  logic [GRAM_W-1:0] rdata_a, rdata_b, rdata;
  logic [CNT_W:0]    uni;
  logic [19:0]       lhs, rhs;

  chjac_ram #(.WIDTH(GRAM_W), .DEPTH(TEXT_MAX)) u_ram_a (
    .clk_i, .we_i(we_a), .waddr_i(cnt_a_q[ADDR_W-1:0]), .wdata_i(g_q),
    .raddr_i(idx_q[ADDR_W-1:0]), .rdata_o(rdata_a)
  );
  chjac_ram #(.WIDTH(GRAM_W), .DEPTH(TEXT_MAX)) u_ram_b (
    .clk_i, .we_i(we_b), .waddr_i(cnt_b_q[ADDR_W-1:0]), .wdata_i(g_q),
    .raddr_i(idx_q[ADDR_W-1:0]), .rdata_o(rdata_b)
  );

  assign rd_b  = (st_q == ST_SCAN) && tob_q;
  assign rdata = rd_b ? rdata_b : rdata_a;
  assign n_sel = rd_b ? cnt_b_q : cnt_a_q;
  assign issue = (idx_q < n_sel);
  assign hit   = cmpv_q && (rdata == g_q);

  assign uni = {1'b0, cnt_a_q} + {1'b0, cnt_b_q} - {1'b0, com_q};
  assign lhs = 20'(com_q) * 20'(den_i);
  assign rhs = 20'(num_i) * 20'(uni);

  assign result_o.valid        = rv_q;
  assign result_o.shared_grams = rsh_q;
  assign result_o.all_grams    = rall_q;
  assign result_o.is_similar   = rsim_q;
  assign result_o.truncated    = rtr_q;

  always_comb begin
    st_d = st_q; cnt_a_d = cnt_a_q; cnt_b_d = cnt_b_q; com_d = com_q;
    idx_d = idx_q; cmpv_d = 1'b0; tob_d = tob_q; g_d = g_q;
    rv_d = rv_q && !result_o.ready;
    rsh_d = rsh_q; rall_d = rall_q; rsim_d = rsim_q; rtr_d = rtr_q;
    pop_o = 1'b0; we_a = 1'b0; we_b = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (!empty_i) begin
          unique case (head_i.kind)
            OP_CLEAR: begin
              pop_o = 1'b1;
              cnt_a_d = '0; cnt_b_d = '0; com_d = '0;
            end
            OP_GRAM: begin
              pop_o = 1'b1;
              g_d = head_i.gram;
              tob_d = head_i.to_b;
              idx_d = '0;
              st_d = ST_SCAN;
            end
            OP_DONE: begin
              if (!rv_q) begin
                pop_o = 1'b1;
                rv_d = 1'b1;
                rtr_d = head_i.ovf;
                if (cnt_a_q == '0 || cnt_b_q == '0) begin
                  rsh_d = '0; rall_d = '0; rsim_d = (num_i == '0);
                end else begin
                  rsh_d = (com_q > CNT_W'(1023)) ? 10'd1023 : com_q[9:0];
                  rall_d = (uni > (CNT_W+1)'(2047)) ? 11'd2047 : uni[10:0];
                  rsim_d = (lhs >= rhs);
                end
                cnt_a_d = '0; cnt_b_d = '0; com_d = '0;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      ST_SCAN, ST_XCHK: begin
        if (issue) begin
          idx_d = idx_q + 1'b1;
          cmpv_d = 1'b1;
        end
        if (hit) begin
          cmpv_d = 1'b0;
          st_d = ST_IDLE;
          if (st_q == ST_XCHK) com_d = com_q + 1'b1;
        end else if (!issue && !cmpv_q) begin
          st_d = ST_IDLE;
          if (st_q == ST_SCAN) begin
            if (!tob_q && cnt_a_q < CNT_W'(TEXT_MAX)) begin
              we_a = 1'b1;
              cnt_a_d = cnt_a_q + 1'b1;
            end else if (tob_q && cnt_b_q < CNT_W'(TEXT_MAX)) begin
              we_b = 1'b1;
              cnt_b_d = cnt_b_q + 1'b1;
              idx_d = '0;
              st_d = ST_XCHK;
            end
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    g_q <= g_d; tob_q <= tob_d;
    rsh_q <= rsh_d; rall_q <= rall_d; rsim_q <= rsim_d; rtr_q <= rtr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cnt_a_q <= '0; cnt_b_q <= '0; com_q <= '0;
      idx_q <= '0; cmpv_q <= 1'b0; rv_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_a_q <= cnt_a_d; cnt_b_q <= cnt_b_d; com_q <= com_d;
      idx_q <= idx_d; cmpv_q <= cmpv_d; rv_q <= rv_d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/chjac_checker.sv
// Port-level assertions for the similarity block, bound to the top level.
`default_nettype none
module chjac_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        res_valid_i,
  input wire logic        res_ready_i,
  input wire logic [9:0]  shared_grams_i,
  input wire logic [10:0] all_grams_i,
  input wire logic        is_similar_i,
  input wire logic        truncated_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(shared_grams_i) &&
      $stable(all_grams_i) && $stable(is_similar_i) && $stable(truncated_i))
    else $error("result word changed while stalled");

  a_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> {1'b0, shared_grams_i} <= all_grams_i)
    else $error("shared count above union count");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && all_grams_i == 11'd0 |-> shared_grams_i == 10'd0)
    else $error("shared grams with empty union");

  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(res_valid_i))
    else $error("result valid unknown");
endmodule

bind char_5gram_jaccard_similarity_core chjac_checker u_chjac_checker (
  .clk_i, .rst_ni,
  .res_valid_i(result_o.valid), .res_ready_i(result_o.ready),
  .shared_grams_i(result_o.shared_grams), .all_grams_i(result_o.all_grams),
  .is_similar_i(result_o.is_similar), .truncated_i(result_o.truncated)
);
`default_nettype wire
